>>> hw/rtl/lrb_pkg.sv
// Shared types, register indexes and state codes for the link reconnect controller.
// No dependencies; every other file refers to this package by scoped names.
package lrb_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CREDENTIALS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_BASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_MAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_FACTOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 3'd5;

  // Reset values of the registers and of the delay state
  localparam logic [31:0] RST_BACKOFF_BASE = 32'd1000;
  localparam logic [31:0] RST_BACKOFF_MAX = 32'd30000;
  localparam logic [3:0] RST_BACKOFF_FACTOR = 4'd2;
  localparam logic [31:0] RST_STEP_MS = 32'd500;
  localparam logic [7:0] RST_STEP_LIMIT = 8'd20;
  localparam logic [31:0] RST_BACKOFF_DELAY = 32'd1000;

  // Reported link state codes
  localparam logic [2:0] LS_IDLE = 3'd0;
  localparam logic [2:0] LS_BEGIN = 3'd1;
  localparam logic [2:0] LS_WAITING = 3'd2;
  localparam logic [2:0] LS_CONNECTED = 3'd3;
  localparam logic [2:0] LS_BACKOFF = 3'd4;

  // Packed stream widths
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_BEGIN     = 5'b00010,
    ST_WAITING   = 5'b00100,
    ST_CONNECTED = 5'b01000,
    ST_BACKOFF   = 5'b10000
  } state_t;

  typedef struct packed {
    logic        credentials_present;
    logic [31:0] backoff_base_ms;
    logic [31:0] backoff_max_ms;
    logic [3:0]  backoff_factor;
    logic [31:0] attempt_step_ms;
    logic [7:0]  attempt_step_limit;
  } cfg_t;

  // Controller context carried from item to item
  typedef struct packed {
    state_t      state;
    logic [31:0] mark_time;
    logic [31:0] backoff_delay;
    logic [7:0]  step_counter;
  } ctx_t;

  function automatic logic [2:0] state_code(input state_t s);
    logic [2:0] code;
    unique case (s)
      ST_BEGIN:     code = LS_BEGIN;
      ST_WAITING:   code = LS_WAITING;
      ST_CONNECTED: code = LS_CONNECTED;
      ST_BACKOFF:   code = LS_BACKOFF;
      default:      code = LS_IDLE;
    endcase
    return code;
  endfunction

endpackage

>>> hw/rtl/lrb_cfg_regs.sv
// Configuration register file of the link reconnect controller.
// Depends on lrb_pkg for the register indexes, reset values and cfg_t.
module lrb_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [lrb_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [31:0]                    wr_data,
  output lrb_pkg::cfg_t                  cfg
);

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.credentials_present <= 1'b0;
      cfg.backoff_base_ms     <= lrb_pkg::RST_BACKOFF_BASE;
      cfg.backoff_max_ms      <= lrb_pkg::RST_BACKOFF_MAX;
      cfg.backoff_factor      <= lrb_pkg::RST_BACKOFF_FACTOR;
      cfg.attempt_step_ms     <= lrb_pkg::RST_STEP_MS;
      cfg.attempt_step_limit  <= lrb_pkg::RST_STEP_LIMIT;
    end else if (wr_en) begin
      unique case (wr_index)
        lrb_pkg::CFG_CREDENTIALS:    cfg.credentials_present <= wr_data[0];
        lrb_pkg::CFG_BACKOFF_BASE:   cfg.backoff_base_ms     <= wr_data;
        lrb_pkg::CFG_BACKOFF_MAX:    cfg.backoff_max_ms      <= wr_data;
        lrb_pkg::CFG_BACKOFF_FACTOR: cfg.backoff_factor      <= wr_data[3:0];
        lrb_pkg::CFG_STEP_MS:        cfg.attempt_step_ms     <= wr_data;
        lrb_pkg::CFG_STEP_LIMIT:     cfg.attempt_step_limit  <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/lrb_step_logic.sv
// Next-context logic for one tick: state transitions, step counting, backoff growth.
// Depends on lrb_pkg for cfg_t, ctx_t and state_t. Purely combinational.
module lrb_step_logic (
  input  lrb_pkg::cfg_t  cfg,
  input  lrb_pkg::ctx_t  ctx,
  input  logic [31:0]    now_ms,
  input  logic           link_up,
  output lrb_pkg::ctx_t  ctx_next,
  output logic           start_connect,
  output logic           drop_link
);

  logic [31:0] elapsed;
  logic        step_due;
  logic        backoff_due;
  logic [7:0]  count_inc;
  logic [35:0] grown;
  logic [31:0] grown_sat;

  // Wrapping elapsed time and the derived expiry flags
  assign elapsed     = now_ms - ctx.mark_time;
  assign step_due    = (elapsed >= cfg.attempt_step_ms);
  assign backoff_due = (elapsed >= ctx.backoff_delay);
  assign count_inc   = ctx.step_counter + 8'd1;

  // Delay growth: full-width product, saturated at the ceiling
  assign grown     = {4'd0, ctx.backoff_delay} * {32'd0, cfg.backoff_factor};
  assign grown_sat = (grown < {4'd0, cfg.backoff_max_ms}) ? grown[31:0] : cfg.backoff_max_ms;

  // Transition logic
  always_comb begin
    ctx_next      = ctx;
    start_connect = 1'b0;
    drop_link     = 1'b0;
    if (cfg.credentials_present) begin
      unique case (ctx.state)
        lrb_pkg::ST_BEGIN: begin
          start_connect         = 1'b1;
          ctx_next.mark_time    = now_ms;
          ctx_next.step_counter = 8'd0;
          ctx_next.state        = lrb_pkg::ST_WAITING;
        end
        lrb_pkg::ST_WAITING: begin
          if (link_up) begin
            ctx_next.backoff_delay = cfg.backoff_base_ms;
            ctx_next.state         = lrb_pkg::ST_CONNECTED;
          end else if (step_due) begin
            ctx_next.mark_time    = now_ms;
            ctx_next.step_counter = count_inc;
            if (count_inc >= cfg.attempt_step_limit) begin
              drop_link      = 1'b1;
              ctx_next.state = lrb_pkg::ST_BACKOFF;
            end
          end
        end
        lrb_pkg::ST_CONNECTED: begin
          if (!link_up) begin
            ctx_next.state = lrb_pkg::ST_BEGIN;
          end
        end
        lrb_pkg::ST_BACKOFF: begin
          if (backoff_due) begin
            ctx_next.backoff_delay = grown_sat;
            ctx_next.state         = lrb_pkg::ST_BEGIN;
          end
        end
        default: begin
          // Idle, and any stray code: only a link-down tick starts a connect
          if (!link_up) begin
            start_connect         = 1'b1;
            ctx_next.mark_time    = now_ms;
            ctx_next.step_counter = 8'd0;
            ctx_next.state        = lrb_pkg::ST_WAITING;
          end else begin
            ctx_next.state = lrb_pkg::ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/link_reconnect_backoff_fsm.sv
// Link reconnect controller with exponential backoff, stream in / stream out.
// Ticks pass through the input register, then the result register.
// Throughput: one tick per cycle while m_tready keeps the result slot free; the context
// update and the 32x4 delay product settle in the single stage between the input register and the result register.
// Reset (rst, synchronous): state idle, mark and step count zero, delay 1000 ms,
// configuration registers back to their defaults, both pipeline stages empty.
module link_reconnect_backoff_fsm (
  input  logic                           clk,
  input  logic                           rst,
  // tick items
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [lrb_pkg::IN_DATA_W-1:0]  s_tdata,   // [31:0] now_ms, [32] link_up
  // result items
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] start_connect, [1] drop_link, [4:2] link_state,
  // [36:5] current_backoff_ms, [44:37] attempt_steps
  output logic [lrb_pkg::OUT_DATA_W-1:0] m_tdata,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);

  lrb_pkg::cfg_t cfg;
  lrb_pkg::ctx_t ctx;
  lrb_pkg::ctx_t ctx_next;

  logic        in_valid;
  logic [31:0] in_now_ms;
  logic        in_link_up;
  logic        advance;
  logic        fire;
  logic        start_connect;
  logic        drop_link;

  assign cfg_ready = 1'b1;

  lrb_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Pipeline flow: result slot frees when empty or taken
  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_now_ms  <= s_tdata[31:0];
      in_link_up <= s_tdata[32];
    end
  end

  lrb_step_logic u_step (
    .cfg           (cfg),
    .ctx           (ctx),
    .now_ms        (in_now_ms),
    .link_up       (in_link_up),
    .ctx_next      (ctx_next),
    .start_connect (start_connect),
    .drop_link     (drop_link)
  );

  // Controller context, updated once per processed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.state         <= lrb_pkg::ST_IDLE;
      ctx.mark_time     <= 32'd0;
      ctx.backoff_delay <= lrb_pkg::RST_BACKOFF_DELAY;
      ctx.step_counter  <= 8'd0;
    end else if (fire) begin
      ctx <= ctx_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {3'd0, ctx_next.step_counter, ctx_next.backoff_delay,
                  lrb_pkg::state_code(ctx_next.state), drop_link, start_connect};
    end
  end

endmodule
